// ===== hw/rtl/cap_pkg.sv =====
// package: shared types and constants for the circular arc profile generator
`default_nettype none
package cap_pkg;
  localparam int unsigned FULL_TURN = 65536;
  localparam logic [31:0] GAIN_Q30 = 32'd652032875;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_START  = 3'd1,
    REG_END    = 3'd2,
    REG_SEGS   = 3'd3,
    REG_SMOOTH = 3'd4,
    REG_CLOSED = 3'd5
  } reg_idx_t;

  function automatic logic [31:0] arc_tab(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41721;     5'd15: r = 32'd20860;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2607;      5'd19: r = 32'd1303;
        5'd20: r = 32'd651;       5'd21: r = 32'd325;
        5'd22: r = 32'd162;       5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/circular_arc_profile_generator.sv =====
// top level: configuration registers, sequencer, vertex scaling and output
//
// channel   direction  handshake               payload
// input     in         start & !busy           in_start_req
// result    out        out_valid, one cycle    vertex, normal, empty_res, last
// config    in         cfg_we                  cfg_index, cfg_data
//
// one division, then one cordic pass per angle: one per smooth vertex,
// three per flat segment, one more for the closing segment. reset is
// synchronous and restores the register defaults; the receiver cannot
// stall, so each result is shown for exactly one cycle.
`default_nettype none
module circular_arc_profile_generator #(
  parameter int unsigned MAX_SEGMENTS      = 31,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_start_req,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data,
  output logic                    out_valid,
  output logic signed [16:0]      out_vertex_x,
  output logic signed [16:0]      out_vertex_y,
  output logic signed [15:0]      out_normal_x,
  output logic signed [15:0]      out_normal_y,
  output logic                    out_empty_res,
  output logic                    out_last
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_TRIG  = 9'b000000100,
    S_WAIT  = 9'b000001000,
    S_EMIT  = 9'b000010000,
    S_CLOSE = 9'b000100000,
    S_CWAIT = 9'b001000000,
    S_CEMIT = 9'b010000000,
    S_EMPTY = 9'b100000000
  } state_t;

  // flat-mode angle role for the current cordic pass
  typedef enum logic [1:0] {
    R_CUR = 2'd0,
    R_NXT = 2'd1,
    R_MID = 2'd2
  } role_t;

  state_t              st_r, st_nxt;
  logic [15:0]         radius_r;
  logic [16:0]         start_r, end_r;
  logic [4:0]          segs_r;
  logic                smooth_r, closed_r;
  logic [16:0]         cv;

  logic [23:0]         step_r, step_nxt, cur_r, cur_nxt, last_ang_r, last_ang_nxt;
  logic [4:0]          seg_i_r, seg_i_nxt;
  role_t               role_r, role_nxt;
  logic signed [16:0]  fx_r, fx_nxt, fy_r, fy_nxt, px_r, px_nxt, py_r, py_nxt;
  logic signed [16:0]  c0x_r, c0x_nxt, c0y_r, c0y_nxt, c1x_r, c1x_nxt, c1y_r, c1y_nxt;
  logic                first_r, first_nxt;
  logic [1:0]          emit_k_r, emit_k_nxt;

  logic                ov_r, ov_nxt, ol_r, ol_nxt, oe_r, oe_nxt;
  logic signed [16:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [15:0]  onx_r, onx_nxt, ony_r, ony_nxt;

  logic                div_go, div_done, cor_go, cor_done;
  logic [23:0]         div_q, cor_ang;
  logic signed [15:0]  sn, cs;
  logic [16:0]         swept;
  logic signed [33:0]  px_prod, py_prod;
  logic signed [16:0]  sx, sy;
  logic [24:0]         mid_sum;

  assign swept = end_r - start_r;

  cap_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go),
    .dividend({swept, 7'd0}), .divisor(segs_r),
    .done(div_done), .quotient(div_q)
  );

  cap_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .go(cor_go), .angle(cor_ang),
    .done(cor_done), .sin_q(sn), .cos_q(cs)
  );

  assign px_prod = $signed({18'd0, radius_r}) * 34'(sn) + 34'sd8192;
  assign py_prod = $signed({18'd0, radius_r}) * 34'(cs) + 34'sd8192;
  assign sx      = 17'(px_prod >>> 14);
  assign sy      = 17'(py_prod >>> 14);
  assign mid_sum = {1'b0, end_r[16:0], 7'd0} + {1'b0, last_ang_r};

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      start_r  <= 17'd0;
      end_r    <= 17'(cap_pkg::FULL_TURN);
      segs_r   <= 5'd16;
      smooth_r <= 1'b1;
      closed_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cap_pkg::REG_RADIUS: radius_r <= cfg_data[15:0];
        cap_pkg::REG_START: begin
          start_r <= cv;
          if (cv > end_r) end_r <= cv;
        end
        cap_pkg::REG_END: begin
          end_r <= cv;
          if (cv < start_r) start_r <= cv;
        end
        cap_pkg::REG_SEGS:
          if (cfg_data[4:0] >= 5'd2 && 32'(cfg_data[4:0]) <= MAX_SEGMENTS)
            segs_r <= cfg_data[4:0];
        cap_pkg::REG_SMOOTH: smooth_r <= cfg_data[0];
        cap_pkg::REG_CLOSED: closed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end
  assign cv = (cfg_data > 17'(cap_pkg::FULL_TURN)) ? 17'(cap_pkg::FULL_TURN) : cfg_data;

  always_comb begin
    st_nxt = st_r;
    step_nxt = step_r; cur_nxt = cur_r; last_ang_nxt = last_ang_r;
    seg_i_nxt = seg_i_r; role_nxt = role_r;
    fx_nxt = fx_r; fy_nxt = fy_r; px_nxt = px_r; py_nxt = py_r;
    c0x_nxt = c0x_r; c0y_nxt = c0y_r; c1x_nxt = c1x_r; c1y_nxt = c1y_r;
    first_nxt = first_r; emit_k_nxt = emit_k_r;
    ov_nxt = 1'b0; ol_nxt = 1'b0; oe_nxt = 1'b0;
    ox_nxt = ox_r; oy_nxt = oy_r; onx_nxt = onx_r; ony_nxt = ony_r;
    div_go = 1'b0; cor_go = 1'b0;
    case (role_r)
      R_NXT:   cor_ang = cur_r - step_r;
      R_MID:   cor_ang = cur_r - {1'b0, step_r[23:1]};
      default: cor_ang = cur_r;
    endcase
    if (st_r == S_CLOSE) cor_ang = mid_sum[24:1];
    case (st_r)
      S_IDLE:
        if (start && in_start_req) begin
          if (swept == 17'd0) st_nxt = S_EMPTY;
          else begin
            div_go = 1'b1;
            st_nxt = S_DIV;
          end
        end
      S_EMPTY: begin
        ov_nxt = 1'b1; ol_nxt = 1'b1; oe_nxt = 1'b1;
        ox_nxt = '0; oy_nxt = '0; onx_nxt = '0; ony_nxt = '0;
        st_nxt = S_IDLE;
      end
      S_DIV:
        if (div_done) begin
          step_nxt  = div_q;
          cur_nxt   = {end_r[16:0], 7'd0};
          seg_i_nxt = '0;
          role_nxt  = R_CUR;
          first_nxt = 1'b1;
          st_nxt    = S_TRIG;
        end
      S_TRIG: begin
        cor_go = 1'b1;
        st_nxt = S_WAIT;
      end
      S_WAIT:
        if (cor_done) st_nxt = S_EMIT;
      S_EMIT: begin
        if (smooth_r) begin
          ov_nxt = 1'b1;
          ox_nxt = sx; oy_nxt = sy; onx_nxt = sn; ony_nxt = cs;
          if (first_r) begin fx_nxt = sx; fy_nxt = sy; end
          first_nxt = 1'b0;
          px_nxt = sx; py_nxt = sy;
          last_ang_nxt = cur_r;
          cur_nxt = cur_r - step_r;
          if (seg_i_r == segs_r) begin
            if (closed_r && (sx != fx_r || sy != fy_r) && !first_r) st_nxt = S_CLOSE;
            else begin ol_nxt = 1'b1; st_nxt = S_IDLE; end
          end else begin
            seg_i_nxt = seg_i_r + 1'b1;
            st_nxt = S_TRIG;
          end
        end else begin
          case (role_r)
            R_CUR: begin
              c0x_nxt = sx; c0y_nxt = sy;
              role_nxt = R_NXT; st_nxt = S_TRIG;
            end
            R_NXT: begin
              c1x_nxt = sx; c1y_nxt = sy;
              role_nxt = R_MID; st_nxt = S_TRIG;
            end
            default: begin
              ov_nxt = 1'b1;
              ox_nxt = c0x_r; oy_nxt = c0y_r; onx_nxt = sn; ony_nxt = cs;
              if (first_r) begin fx_nxt = c0x_r; fy_nxt = c0y_r; end
              first_nxt = 1'b0;
              emit_k_nxt = 2'd1;
              st_nxt = S_CEMIT;
            end
          endcase
        end
      end
      S_CEMIT: begin
        // second result of a flat segment (emit_k 1) or of the closing pair (2)
        ov_nxt = 1'b1;
        if (emit_k_r == 2'd1) begin
          ox_nxt = c1x_r; oy_nxt = c1y_r;
          px_nxt = c1x_r; py_nxt = c1y_r;
          last_ang_nxt = cur_r - step_r;
          cur_nxt = cur_r - step_r;
          role_nxt = R_CUR;
          if (seg_i_r == segs_r - 5'd1) begin
            if (closed_r && (c1x_r != fx_r || c1y_r != fy_r)) st_nxt = S_CLOSE;
            else begin ol_nxt = 1'b1; st_nxt = S_IDLE; end
          end else begin
            seg_i_nxt = seg_i_r + 1'b1;
            st_nxt = S_TRIG;
          end
        end else begin
          ox_nxt = fx_r; oy_nxt = fy_r;
          ol_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_CLOSE: begin
        cor_go = 1'b1;
        st_nxt = S_CWAIT;
      end
      S_CWAIT:
        if (cor_done) begin
          ov_nxt = 1'b1;
          ox_nxt = px_r; oy_nxt = py_r; onx_nxt = -sn; ony_nxt = -cs;
          emit_k_nxt = 2'd2;
          st_nxt = S_CEMIT;
        end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    step_r <= step_nxt; cur_r <= cur_nxt; last_ang_r <= last_ang_nxt;
    seg_i_r <= seg_i_nxt; role_r <= role_nxt;
    fx_r <= fx_nxt; fy_r <= fy_nxt; px_r <= px_nxt; py_r <= py_nxt;
    c0x_r <= c0x_nxt; c0y_r <= c0y_nxt; c1x_r <= c1x_nxt; c1y_r <= c1y_nxt;
    first_r <= first_nxt; emit_k_r <= emit_k_nxt;
    ol_r <= ol_nxt; oe_r <= oe_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; onx_r <= onx_nxt; ony_r <= ony_nxt;
  end

  assign busy          = (st_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_vertex_x  = ox_r;
  assign out_vertex_y  = oy_r;
  assign out_normal_x  = onx_r;
  assign out_normal_y  = ony_r;
  assign out_empty_res = oe_r;
  assign out_last      = ol_r;
endmodule
`default_nettype wire

// ===== hw/rtl/cap_cordic.sv =====
// iterative rotation cordic: 24 bit angle in, q1.14 sine and cosine out
`default_nettype none
module cap_cordic #(
  parameter int unsigned ITERS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [23:0]        angle,
  output logic                    done,
  output logic signed [15:0]      sin_q,
  output logic signed [15:0]      cos_q
);
  localparam int unsigned IW = $clog2(ITERS + 1);

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [IW-1:0]      it_r, it_nxt;
  logic [1:0]         q_r, q_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [15:0] sn_r, sn_nxt, cs_r, cs_nxt;
  logic signed [33:0] dx, dy, tab;
  logic signed [15:0] c16, s16;

  function automatic logic signed [15:0] q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) r = 34'sd16384;
      if (r < -34'sd16384) r = -34'sd16384;
      return r[15:0];
    end
  endfunction

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    q_nxt    = q_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    sn_nxt   = sn_r;
    cs_nxt   = cs_r;
    dx       = y_r >>> it_r;
    dy       = x_r >>> it_r;
    tab      = $signed({2'b00, cap_pkg::arc_tab(5'(it_r))});
    c16      = q14(x_r);
    s16      = q14(y_r);
    if (go) begin
      run_nxt = 1'b1;
      it_nxt  = '0;
      q_nxt   = angle[22:21];
      x_nxt   = $signed({2'b00, cap_pkg::GAIN_Q30});
      y_nxt   = '0;
      z_nxt   = $signed({4'd0, angle[20:0], 9'd0});
    end else if (run_r) begin
      if (it_r == IW'(ITERS) || it_r == IW'(24)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        case (q_r)
          2'd0: begin cs_nxt = c16; sn_nxt = s16; end
          2'd1: begin cs_nxt = -s16; sn_nxt = c16; end
          2'd2: begin cs_nxt = -c16; sn_nxt = -s16; end
          default: begin cs_nxt = s16; sn_nxt = -c16; end
        endcase
      end else begin
        it_nxt = it_r + 1'b1;
        if (z_r >= 0) begin
          x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - tab;
        end else begin
          x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + tab;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    it_r <= it_nxt;
    q_r  <= q_nxt;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    sn_r <= sn_nxt;
    cs_r <= cs_nxt;
  end

  assign done  = done_r;
  assign sin_q = sn_r;
  assign cos_q = cs_r;
endmodule
`default_nettype wire

// ===== hw/rtl/cap_div.sv =====
// restoring divider for the angle step: 24 bit dividend over 5 bit count
`default_nettype none
module cap_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [23:0] dividend,
  input  wire logic [4:0]  divisor,
  output logic             done,
  output logic [23:0]      quotient
);
  logic        run_r, run_nxt, done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] q_r, q_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [4:0]  dv_r, dv_nxt;
  logic [5:0]  trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    trial    = {rem_r[4:0], q_r[23]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt   = dividend;
      rem_nxt = '0;
      dv_nxt  = divisor;
    end else if (run_r) begin
      q_nxt = {q_r[22:0], 1'b0};
      if (trial >= {1'b0, dv_r}) begin
        rem_nxt  = trial - {1'b0, dv_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 5'd23) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// testbench for the circular arc profile generator: request driver, result checker
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               empty;
    logic               last;
  } arc_point_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               in_start_req = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = 3'd0;
  logic [16:0]        cfg_data = 17'd0;
  logic               busy;
  logic               out_valid;
  logic signed [16:0] out_vertex_x;
  logic signed [16:0] out_vertex_y;
  logic signed [15:0] out_normal_x;
  logic signed [15:0] out_normal_y;
  logic               out_empty_res;
  logic               out_last;

  circular_arc_profile_generator dut (.*);

  always #5 clk = ~clk;

  // register mirror
  logic [15:0] m_radius = 16'd256;
  logic [16:0] m_start = 17'd0;
  logic [16:0] m_end = 17'd65536;
  logic [4:0]  m_segs = 5'd16;
  logic        m_smooth = 1'b1;
  logic        m_closed = 1'b0;

  logic       pending_reqs[$];
  arc_point_t expected_points[$];
  int         idle_pct = 0;
  int         fail_count = 0;
  int         requests_done = 0;
  int         points_seen = 0;

  function automatic int round_q14(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return int'(r);
  endfunction

  function automatic void sin_cos(input logic [23:0] ang, output int sn, output int cs);
    logic [31:0] a;
    longint x, y, z, dx, dy;
    int c, s;
    a = {ang[22:0], 9'd0};
    x = longint'(cap_pkg::GAIN_Q30);
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(cap_pkg::arc_tab(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(cap_pkg::arc_tab(i[4:0]));
      end
    end
    c = round_q14(x);
    s = round_q14(y);
    case (a[31:30])
      2'd0: begin cs = c; sn = s; end
      2'd1: begin cs = -s; sn = c; end
      2'd2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endfunction

  function automatic int scale_q88(int t);
    return int'((longint'(m_radius) * t + 8192) >>> 14);
  endfunction

  function automatic arc_point_t mk_point(int vx, int vy, int nx, int ny);
    arc_point_t p;
    p.vx = vx[16:0]; p.vy = vy[16:0]; p.nx = nx[15:0]; p.ny = ny[15:0];
    p.empty = 1'b0; p.last = 1'b0;
    return p;
  endfunction

  function automatic void predict_arc(logic req);
    arc_point_t pts[$];
    arc_point_t p;
    int unsigned swept, n, end7, step, cur, nxt, mid, last_ang;
    int s0, c0, s1, c1, ns, nc, fx, fy, lx, ly;
    if (!req) return;
    swept = (m_end >= m_start) ? m_end - m_start : 0;
    if (swept == 0) begin
      p = mk_point(0, 0, 0, 0);
      p.empty = 1'b1; p.last = 1'b1;
      expected_points = {expected_points, p};
      return;
    end
    n = m_segs;
    end7 = m_end << 7;
    step = ((swept << 7) / n) & 24'hFFFFFF;
    cur = end7 & 24'hFFFFFF;
    last_ang = 0;
    if (m_smooth) begin
      for (int i = 0; i <= n; i++) begin
        sin_cos(cur[23:0], s0, c0);
        lx = scale_q88(s0); ly = scale_q88(c0);
        if (i == 0) begin fx = lx; fy = ly; end
        pts = {pts, mk_point(lx, ly, s0, c0)};
        last_ang = cur;
        cur = (cur - step) & 24'hFFFFFF;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        nxt = (cur - step) & 24'hFFFFFF;
        mid = (cur - (step >> 1)) & 24'hFFFFFF;
        sin_cos(cur[23:0], s0, c0);
        sin_cos(nxt[23:0], s1, c1);
        sin_cos(mid[23:0], ns, nc);
        if (i == 0) begin fx = scale_q88(s0); fy = scale_q88(c0); end
        lx = scale_q88(s1); ly = scale_q88(c1);
        pts = {pts, mk_point(scale_q88(s0), scale_q88(c0), ns, nc)};
        pts = {pts, mk_point(lx, ly, ns, nc)};
        last_ang = nxt;
        cur = nxt;
      end
    end
    if (m_closed && (lx[16:0] != fx[16:0] || ly[16:0] != fy[16:0])) begin
      mid = ((end7 + last_ang) >> 1) & 24'hFFFFFF;
      sin_cos(mid[23:0], ns, nc);
      pts = {pts, mk_point(lx, ly, -ns, -nc)};
      pts = {pts, mk_point(fx, fy, -ns, -nc)};
    end
    pts[pts.size() - 1].last = 1'b1;
    expected_points = {expected_points, pts};
  endfunction

  // request driver
  always @(posedge clk) begin
    logic go;
    if (rst_n) begin
      if (start && !busy) begin
        predict_arc(in_start_req);
        requests_done++;
      end
      if (!start || !busy) begin
        go = pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct;
        start <= go;
        if (go) in_start_req <= pending_reqs.pop_front();
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    arc_point_t e;
    if (rst_n && out_valid) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        $error("unexpected transaction: x=%0d y=%0d", out_vertex_x, out_vertex_y);
        fail_count++;
      end else begin
        e = expected_points.pop_front();
        if (out_vertex_x !== e.vx) begin
          $error("vertex_x expected %0d got %0d", e.vx, out_vertex_x); fail_count++;
        end
        if (out_vertex_y !== e.vy) begin
          $error("vertex_y expected %0d got %0d", e.vy, out_vertex_y); fail_count++;
        end
        if (out_normal_x !== e.nx) begin
          $error("normal_x expected %0d got %0d", e.nx, out_normal_x); fail_count++;
        end
        if (out_normal_y !== e.ny) begin
          $error("normal_y expected %0d got %0d", e.ny, out_normal_y); fail_count++;
        end
        if (out_empty_res !== e.empty) begin
          $error("empty_res expected %0d got %0d", e.empty, out_empty_res); fail_count++;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d got %0d", e.last, out_last); fail_count++;
        end
      end
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || start || expected_points.size() != 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] data);
    logic [16:0] v;
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    v = (data > 17'd65536) ? 17'd65536 : data;
    case (idx)
      cap_pkg::REG_RADIUS: m_radius = data[15:0];
      cap_pkg::REG_START: begin m_start = v; if (m_start > m_end) m_end = m_start; end
      cap_pkg::REG_END: begin m_end = v; if (m_end < m_start) m_start = m_end; end
      cap_pkg::REG_SEGS: if (data[4:0] >= 2) m_segs = data[4:0];
      cap_pkg::REG_SMOOTH: m_smooth = data[0];
      cap_pkg::REG_CLOSED: m_closed = data[0];
      default: ;
    endcase
  endtask

  task automatic run_batch(int count);
    for (int i = 0; i < count; i++) pending_reqs = {pending_reqs, ($urandom_range(9) != 0)};
    wait_idle();
  endtask

  task automatic run_one(logic req);
    pending_reqs = {pending_reqs, req};
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed
    run_one(1'b1);
    run_one(1'b0);
    write_reg(cap_pkg::REG_SMOOTH, 17'd0);
    write_reg(cap_pkg::REG_CLOSED, 17'd1);
    write_reg(cap_pkg::REG_SEGS, 17'd31);
    write_reg(cap_pkg::REG_RADIUS, 17'd65535);
    write_reg(cap_pkg::REG_START, 17'd1000);
    run_one(1'b1);
    write_reg(cap_pkg::REG_SMOOTH, 17'd1);
    write_reg(cap_pkg::REG_RADIUS, 17'd0);
    write_reg(cap_pkg::REG_SEGS, 17'd2);
    run_one(1'b1);
    write_reg(cap_pkg::REG_SEGS, 17'd1);
    write_reg(cap_pkg::REG_SEGS, 17'd0);
    write_reg(cap_pkg::REG_RADIUS, 17'h1FFFF);
    write_reg(cap_pkg::REG_START, 17'd0);
    run_one(1'b1);
    write_reg(cap_pkg::REG_START, 17'h1FFFF);
    run_one(1'b1);
    write_reg(cap_pkg::REG_END, 17'd300);
    write_reg(3'd6, 17'h1FFFF);
    write_reg(3'd7, 17'd5);
    run_one(1'b1);
    write_reg(cap_pkg::REG_SMOOTH, 17'd0);
    write_reg(cap_pkg::REG_START, 17'd299);
    run_one(1'b1);
    write_reg(cap_pkg::REG_START, 17'd0);
    write_reg(cap_pkg::REG_END, 17'd65536);
    run_one(1'b1);
    write_reg(cap_pkg::REG_SMOOTH, 17'd1);
    write_reg(cap_pkg::REG_SEGS, 17'd31);
    run_one(1'b1);
    // random phases
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1, 2: idle_pct = 57;
        default: idle_pct = 38;
      endcase
      if ($urandom_range(3) == 0) write_reg(cap_pkg::REG_RADIUS, 17'($urandom_range(131071)));
      else write_reg(cap_pkg::REG_RADIUS, 17'($urandom_range(2048)));
      if ($urandom_range(1)) write_reg(cap_pkg::REG_START, 17'($urandom_range(131071)));
      else write_reg(cap_pkg::REG_START, 17'($urandom_range(65536)));
      if ($urandom_range(5) == 0) write_reg(cap_pkg::REG_END, m_start);
      else write_reg(cap_pkg::REG_END, 17'($urandom_range(131071)));
      write_reg(cap_pkg::REG_SEGS, 17'(($urandom_range(3) == 0) ? $urandom_range(31)
                : $urandom_range(2, 8) | ($urandom_range(131071) & 17'h1FFE0)));
      write_reg(cap_pkg::REG_SMOOTH, 17'($urandom_range(131071)));
      write_reg(cap_pkg::REG_CLOSED, 17'($urandom_range(131071)));
      if ($urandom_range(7) == 0)
        write_reg(3'($urandom_range(7, 6)), 17'($urandom_range(131071)));
      run_batch(6);
    end
    repeat (50) @(posedge clk);
    $display("covered %0d requests and %0d result transactions over 24 register settings",
             requests_done, points_seen);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== circular_arc_profile_generator.f =====
hw/rtl/cap_pkg.sv
hw/rtl/cap_cordic.sv
hw/rtl/cap_div.sv
hw/rtl/circular_arc_profile_generator.sv
bench/testbench.sv
